// ----- rtl/gbk_utf8_byte_stream_classifier_macros.svh -----
// Assertion macros for the GBK / UTF-8 byte stream classifier.
// Users must have clk_i and rst_ni in scope; no other dependencies.
`ifndef GBK_UTF8_BYTE_STREAM_CLASSIFIER_MACROS_SVH
`define GBK_UTF8_BYTE_STREAM_CLASSIFIER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GUC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GUC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/gbkutf_pkg.sv -----
// Shared types, constants and a helper function of the GBK / UTF-8 classifier.
// No dependencies.
`timescale 1ns / 1ps

package gbkutf_pkg;

  localparam int WinDepth  = 8;
  localparam int ByteW     = 8;
  localparam int WinW      = WinDepth * ByteW;
  localparam int FillW     = 4;
  localparam int OnesW     = 4;
  localparam int OutCountW = 25;
  localparam int OutDataW  = 56;

  localparam logic [7:0] GbkLeadMin  = 8'd161;
  localparam logic [7:0] GbkLeadMax  = 8'd247;
  localparam logic [7:0] GbkTrailMin = 8'd161;
  localparam logic [7:0] GbkTrailMax = 8'd254;

  typedef struct packed {
    logic push;
    logic step;
    logic load_out;
    logic clear;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_done;
  } dp_stat_t;

  // Number of leading ones of a byte, 0 to 8.
  function automatic logic [OnesW-1:0] leading_ones(input logic [7:0] b);
    logic [OnesW-1:0] n;
    logic             run;
    n   = '0;
    run = 1'b1;
    for (int i = 7; i >= 0; i--) begin
      run = run & b[i];
      if (run) begin
        n = n + OnesW'(1);
      end
    end
    return n;
  endfunction

endpackage

// ----- rtl/gbk_utf8_byte_stream_classifier.sv -----
// Channel   Dir  Width  Contents
// s_axis    in   8      tdata: data_byte; tlast: last_byte
// m_axis    out  56     tdata: utf8_detected, utf8_bytes, gbk_bytes
//
// Each byte is accepted, then the UTF-8 window steps while the scan is not done, and
// the scan then reports done: a byte that only extends a pending run needs no step,
// one that retires a run needs one step, and a failed check rescans up to eight bytes.
// The datapath makes a single window step per cycle.
// Reset is asynchronous and active low; the lookahead window is not cleared.
// The final byte of a stream waits in the scan until the result register is free.
// Top level of the GBK / UTF-8 classifier; depends on gbkutf_pkg, gbkutf_ctrl,
// gbkutf_dpath and the assertion macro header.
`timescale 1ns / 1ps
`include "gbk_utf8_byte_stream_classifier_macros.svh"

module gbk_utf8_byte_stream_classifier #(
  parameter logic [32:0] MAX_STREAM_BYTES = 33'd16777216
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata    // [0] utf8_detected, [25:1] utf8_bytes,
                                      // [50:26] gbk_bytes, [55:51] zero
);

  gbkutf_pkg::dp_cmd_t  cmd;
  gbkutf_pkg::dp_stat_t stat;

  gbkutf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_last_i   (s_axis_tlast),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  gbkutf_dpath #(
    .MAX_STREAM_BYTES (MAX_STREAM_BYTES)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .data_byte_i (s_axis_tdata),
    .last_byte_i (s_axis_tlast),
    .result_o    (m_axis_tdata)
  );

  `GUC_ASSERT_SAME(a_step_needs_work, cmd.step, !stat.scan_done, "window step with scan done")
  `GUC_ASSERT_SAME(a_load_when_done, cmd.load_out, stat.scan_done && !cmd.step, "early result")
  `GUC_ASSERT_NEXT(a_scan_after_item, s_axis_tvalid && s_axis_tready, !s_axis_tready, "no scan cycle")

endmodule

// ----- rtl/gbkutf_ctrl.sv -----
// Controller of the GBK / UTF-8 classifier: item handshakes and scan sequencing.
// Depends on gbkutf_pkg.
`timescale 1ns / 1ps

module gbkutf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_last_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output gbkutf_pkg::dp_cmd_t cmd_o,
  input  gbkutf_pkg::dp_stat_t stat_i
);

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  state_e state_q;
  logic   last_q;
  logic   out_valid_q;
  logic   accept;
  logic   emit;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && in_ready_o;
  // The final item of a stream waits here until the result register is free.
  assign emit        = (state_q == ST_SCAN) && stat_i.scan_done && last_q &&
                       (!out_valid_q || out_ready_i);

  always_comb begin
    cmd_o          = '0;
    cmd_o.push     = accept;
    cmd_o.step     = (state_q == ST_SCAN) && !stat_i.scan_done;
    cmd_o.load_out = emit;
    cmd_o.clear    = emit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_SCAN;
            last_q  <= in_last_i;
          end
        end
        ST_SCAN: begin
          if (emit || (stat_i.scan_done && !last_q)) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/gbkutf_dpath.sv -----
// Datapath of the GBK / UTF-8 classifier: GBK pairing, UTF-8 lookahead window,
// saturating counters and the result register. Depends on gbkutf_pkg.
`timescale 1ns / 1ps

module gbkutf_dpath #(
  parameter logic [32:0] MAX_STREAM_BYTES = 33'd16777216
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  gbkutf_pkg::dp_cmd_t               cmd_i,
  output gbkutf_pkg::dp_stat_t              stat_o,
  input  logic [7:0]                        data_byte_i,
  input  logic                              last_byte_i,
  output logic [gbkutf_pkg::OutDataW-1:0]   result_o
);

  localparam int CntW = $clog2(MAX_STREAM_BYTES + 33'd1);
  localparam logic [CntW:0] CapW = (CntW + 1)'(MAX_STREAM_BYTES);

  // Window holds the unscanned UTF-8 bytes, scan position in the low byte.
  logic [gbkutf_pkg::WinW-1:0]   win_q, win_d;
  logic [gbkutf_pkg::FillW-1:0]  fill_q, fill_d;
  logic                          lead_pend_q, lead_pend_d;
  logic [7:0]                    lead_val_q, lead_val_d;
  logic [CntW-1:0]               utf_cnt_q, utf_cnt_d;
  logic [CntW-1:0]               gbk_cnt_q, gbk_cnt_d;
  logic                          det_q;
  logic [gbkutf_pkg::OutCountW-1:0] utf_out_q, gbk_out_q;

  logic [gbkutf_pkg::OnesW-1:0]  ones;
  logic                          pass;
  logic [gbkutf_pkg::FillW-1:0]  drop;
  logic [CntW:0]                 utf_sum, gbk_sum;
  logic                          pair_ok;

  assign ones = gbkutf_pkg::leading_ones(win_q[7:0]);

  always_comb begin
    pass = 1'b1;
    for (int j = 1; j < gbkutf_pkg::WinDepth; j++) begin
      if ((gbkutf_pkg::OnesW'(j) < ones) && !win_q[j*8+7]) begin
        pass = 1'b0;
      end
    end
  end

  assign stat_o.scan_done = (fill_q == '0) ||
                            ((ones > gbkutf_pkg::OnesW'(1)) && (fill_q < ones));

  assign drop    = ((ones > gbkutf_pkg::OnesW'(1)) && pass) ? ones
                                                            : gbkutf_pkg::FillW'(1);
  assign utf_sum = {1'b0, utf_cnt_q} + (CntW + 1)'(ones);
  assign gbk_sum = {1'b0, gbk_cnt_q} + (CntW + 1)'(2);
  assign pair_ok = (lead_val_q >= gbkutf_pkg::GbkLeadMin) &&
                   (lead_val_q <= gbkutf_pkg::GbkLeadMax) &&
                   (data_byte_i >= gbkutf_pkg::GbkTrailMin) &&
                   (data_byte_i <= gbkutf_pkg::GbkTrailMax);

  always_comb begin
    win_d       = win_q;
    fill_d      = fill_q;
    lead_pend_d = lead_pend_q;
    lead_val_d  = lead_val_q;
    utf_cnt_d   = utf_cnt_q;
    gbk_cnt_d   = gbk_cnt_q;
    if (cmd_i.clear) begin
      fill_d      = '0;
      lead_pend_d = 1'b0;
      lead_val_d  = '0;
      utf_cnt_d   = '0;
      gbk_cnt_d   = '0;
    end else if (cmd_i.push) begin
      // The window never holds a full run when idle, so a slot is always free.
      for (int i = 0; i < gbkutf_pkg::WinDepth; i++) begin
        if (fill_q == gbkutf_pkg::FillW'(i)) begin
          win_d[i*8 +: 8] = data_byte_i;
        end
      end
      fill_d = fill_q + gbkutf_pkg::FillW'(1);
      if (lead_pend_q) begin
        if (pair_ok) begin
          gbk_cnt_d = (gbk_sum > CapW) ? CntW'(MAX_STREAM_BYTES) : CntW'(gbk_sum);
        end
        lead_pend_d = 1'b0;
      end else if (data_byte_i[7] && !last_byte_i) begin
        lead_pend_d = 1'b1;
        lead_val_d  = data_byte_i;
      end
    end else if (cmd_i.step) begin
      if ((ones > gbkutf_pkg::OnesW'(1)) && pass) begin
        utf_cnt_d = (utf_sum > CapW) ? CntW'(MAX_STREAM_BYTES) : CntW'(utf_sum);
      end
      win_d  = win_q >> {drop, 3'b000};
      fill_d = (drop >= fill_q) ? '0 : (fill_q - drop);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      lead_pend_q <= 1'b0;
      lead_val_q  <= '0;
      utf_cnt_q   <= '0;
      gbk_cnt_q   <= '0;
    end else begin
      fill_q      <= fill_d;
      lead_pend_q <= lead_pend_d;
      lead_val_q  <= lead_val_d;
      utf_cnt_q   <= utf_cnt_d;
      gbk_cnt_q   <= gbk_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
    if (cmd_i.load_out) begin
      det_q     <= (utf_cnt_q > gbk_cnt_q);
      utf_out_q <= gbkutf_pkg::OutCountW'(utf_cnt_q);
      gbk_out_q <= gbkutf_pkg::OutCountW'(gbk_cnt_q);
    end
  end

  assign result_o = {5'b0, gbk_out_q, utf_out_q, det_q};

endmodule
